@@ sv/bbts_pkg.sv @@
// Shared types and constants of the bilinear byte texture sampler.
package bbts_pkg;

    // Configuration register layout.
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'd1;

    // A clamped dimension never exceeds the 9-bit register value, but a zero value becomes 1.
    localparam int DIM_W = 9;
    localparam int WGT_W = 17;
    localparam int ACC_W = 24;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_FETCH  = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  texel_x;
        logic [7:0]  texel_y;
        logic [7:0]  texel_value;
        logic [15:0] coord_u;
        logic [15:0] coord_v;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  fetched_texel;
        logic [15:0] sample_value;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_FETCH,
        CMD_SAMPLE
    } t_cmd_kind;

    // One command from the front end to the store sequencer.
    typedef struct packed {
        t_cmd_kind        kind;
        logic [DIM_W-1:0] x0;
        logic [DIM_W-1:0] x1;
        logic [DIM_W-1:0] y0;
        logic [DIM_W-1:0] y1;
        logic [7:0]       fu;
        logic [7:0]       fv;
        logic [7:0]       value;
    } t_cmd;

endpackage

@@ sv/bilinear_byte_texture_sampler.sv @@
// Top level of the bilinear byte texture sampler.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): a transfer carries one
// item; mode write stores a byte, mode fetch reads one back, mode sample
// blends the four texels around (u, v) with repeat wrap.
// Output channel (o_out_valid / i_out_stall / o_out_item): fetch and sample
// items give one result each, in order; writes and mode 3 give none.
// Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) sets width and height
// and must be written only while no item is in flight; no logic enforces it.
// A read waits until its result will find the one-entry output register
// free, so a new read does not begin while the last one's result is still
// on its way there; writes issue without that wait. The single-port texel
// store reads one texel a cycle when not held back, so sample taps go in turn.
// Reset clears all control state and sets both dimensions to 256; the store
// content is not cleared. When the receiver stalls, the output holds, the
// back end stops before its next read item, and the two-entry queue and
// input register fill before o_in_stall rises.
module bilinear_byte_texture_sampler #(
    parameter int MAX_DIM     = 256,
    parameter int STORE_DEPTH = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bbts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbts_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bbts_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bbts_pkg::t_out_item             o_out_item
);
    import bbts_pkg::*;

    t_cmd             cmd_in;
    t_cmd             cmd_head;
    logic             cmd_push;
    logic             q_full;
    logic             q_empty;
    logic             cmd_pop;
    logic [DIM_W-1:0] eff_w;

    bbts_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_cmd_push (cmd_push),
        .i_q_full   (q_full),
        .o_cmd      (cmd_in),
        .o_eff_w    (eff_w)
    );

    bbts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (cmd_pop),
        .o_empty (q_empty),
        .o_head  (cmd_head)
    );

    bbts_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (cmd_head),
        .i_empty     (q_empty),
        .o_pop       (cmd_pop),
        .i_eff_w     (eff_w),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

@@ sv/bbts_front.sv @@
// Front end: configuration registers, input register and item classification.
module bbts_front #(
    parameter int MAX_DIM = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bbts_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bbts_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bbts_pkg::t_in_item               i_in_item,
    output logic                             o_cmd_push,
    input  logic                             i_q_full,
    output bbts_pkg::t_cmd                   o_cmd,
    output logic [bbts_pkg::DIM_W-1:0]       o_eff_w
);
    import bbts_pkg::*;

    localparam int SU_W = 16 + DIM_W;

    logic [CFG_W-1:0] r_tex_w;
    logic [CFG_W-1:0] r_tex_h;
    logic             r_valid;
    t_in_item         r_item;

    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [SU_W-1:0]  su;
    logic [SU_W-1:0]  sv;
    logic [DIM_W-1:0] x0;
    logic [DIM_W-1:0] y0;
    logic [DIM_W:0]   x0_inc;
    logic [DIM_W:0]   y0_inc;
    logic             drop;
    logic             accept;
    logic             done;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
        logic [31:0] v;
        v = 32'(d);
        if (d == '0) begin
            v = 32'd1;
        end else if (32'(d) > 32'(MAX_DIM)) begin
            v = 32'(MAX_DIM);
        end
        return v[DIM_W-1:0];
    endfunction

    assign eff_w = eff_dim(r_tex_w);
    assign eff_h = eff_dim(r_tex_h);
    assign o_eff_w = eff_w;

    // Scale the Q0.16 coordinates to texel space; integer part and 8-bit fraction.
    assign su = SU_W'(r_item.coord_u) * SU_W'(eff_w - DIM_W'(1));
    assign sv = SU_W'(r_item.coord_v) * SU_W'(eff_h - DIM_W'(1));
    assign x0 = su[SU_W-1:16];
    assign y0 = sv[SU_W-1:16];
    assign x0_inc = {1'b0, x0} + (DIM_W+1)'(1);
    assign y0_inc = {1'b0, y0} + (DIM_W+1)'(1);

    always_comb begin
        o_cmd = '0;
        drop  = 1'b0;
        case (r_item.mode)
            MODE_WRITE: begin
                o_cmd.kind  = CMD_WRITE;
                o_cmd.x0    = DIM_W'(r_item.texel_x);
                o_cmd.y0    = DIM_W'(r_item.texel_y);
                o_cmd.value = r_item.texel_value;
                drop = (DIM_W'(r_item.texel_x) >= eff_w) ||
                       (DIM_W'(r_item.texel_y) >= eff_h);
            end
            MODE_FETCH: begin
                o_cmd.kind = CMD_FETCH;
                o_cmd.x0   = DIM_W'(r_item.texel_x);
                o_cmd.y0   = DIM_W'(r_item.texel_y);
            end
            MODE_SAMPLE: begin
                o_cmd.kind = CMD_SAMPLE;
                o_cmd.x0   = x0;
                o_cmd.y0   = y0;
                // Repeat wrap: the neighbor past the last column or row wraps to index zero.
                o_cmd.x1   = (x0_inc >= {1'b0, eff_w}) ? '0 : x0_inc[DIM_W-1:0];
                o_cmd.y1   = (y0_inc >= {1'b0, eff_h}) ? '0 : y0_inc[DIM_W-1:0];
                o_cmd.fu   = su[15:8];
                o_cmd.fv   = sv[15:8];
            end
            default: begin
                drop = 1'b1;
            end
        endcase
    end

    assign done       = r_valid && (drop || !i_q_full);
    assign o_cmd_push = r_valid && !drop && !i_q_full;
    assign o_in_stall = r_valid && !done;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= CFG_W'(256);
            r_tex_h <= CFG_W'(256);
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TEX_WIDTH:  r_tex_w <= i_cfg_data;
                    REG_TEX_HEIGHT: r_tex_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (done) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
    end

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_in_stall) |=> (r_valid && $stable(r_item)))
        else $error("front item changed while stalled");

    a_dims_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eff_w != '0) && (eff_h != '0))
        else $error("clamped texture dimension is zero");

endmodule

@@ sv/bbts_fifo.sv @@
// Two-entry command queue between the front end and the store sequencer.
module bbts_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bbts_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output bbts_pkg::t_cmd  o_head
);
    import bbts_pkg::*;

    t_cmd       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("command queue overflow or underflow");

endmodule

@@ sv/bbts_back.sv @@
// Back end: texel store, read sequencer and bilinear accumulator.
module bbts_back #(
    parameter int STORE_DEPTH = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bbts_pkg::t_cmd              i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  logic [bbts_pkg::DIM_W-1:0]  i_eff_w,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bbts_pkg::t_out_item         o_out_item
);
    import bbts_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int PROD_W = 2 * DIM_W + 1;
    localparam int FULL_W = (ADDR_W > PROD_W) ? ADDR_W : PROD_W;

    logic [7:0]       r_store [STORE_DEPTH];
    logic [1:0]       r_tap;
    logic             r_iss_valid;
    logic             r_iss_last;
    logic             r_iss_first;
    logic             r_iss_sample;
    logic [WGT_W-1:0] r_weight;
    logic [7:0]       r_rd_data;
    logic [ACC_W-1:0] r_acc;
    logic             r_out_valid;
    t_out_item        r_out;

    logic              out_xfer;
    logic              out_free;
    logic              issue;
    logic              last;
    logic [DIM_W-1:0]  col;
    logic [DIM_W-1:0]  row;
    logic [FULL_W-1:0] addr_full;
    logic [ADDR_W-1:0] addr;
    logic [8:0]        wgt_u;
    logic [8:0]        wgt_v;
    logic [17:0]       wgt;
    logic [ACC_W-1:0]  sum;

    assign out_xfer = r_out_valid && !i_out_stall;
    // A read command may begin only if its result finds the output register free.
    assign out_free = !(r_iss_valid && r_iss_last) && (!r_out_valid || out_xfer);
    assign issue    = !i_empty &&
                      ((i_head.kind == CMD_WRITE) || (r_tap != 2'd0) || out_free);
    assign last     = (i_head.kind != CMD_SAMPLE) || (r_tap == 2'd3);
    assign o_pop    = issue && last;

    // Tap order: (x0,y0), (x1,y0), (x0,y1), (x1,y1).
    assign col = r_tap[0] ? i_head.x1 : i_head.x0;
    assign row = r_tap[1] ? i_head.y1 : i_head.y0;
    assign addr_full = FULL_W'(row) * FULL_W'(i_eff_w) + FULL_W'(col);
    assign addr = addr_full[ADDR_W-1:0];

    assign wgt_u = r_tap[0] ? {1'b0, i_head.fu} : 9'd256 - {1'b0, i_head.fu};
    assign wgt_v = r_tap[1] ? {1'b0, i_head.fv} : 9'd256 - {1'b0, i_head.fv};
    assign wgt   = 18'(wgt_u) * 18'(wgt_v);

    assign sum = (r_iss_first ? '0 : r_acc) + ACC_W'(r_rd_data) * ACC_W'(r_weight);

    always_ff @(posedge i_clk) begin
        if (issue) begin
            if (i_head.kind == CMD_WRITE) begin
                r_store[addr] <= i_head.value;
            end else begin
                r_rd_data <= r_store[addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap       <= 2'd0;
            r_iss_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_tap <= last ? 2'd0 : r_tap + 2'd1;
            end
            r_iss_valid <= issue && (i_head.kind != CMD_WRITE);
            if (r_iss_valid && r_iss_last) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss_last   <= last;
        r_iss_first  <= (r_tap == 2'd0);
        r_iss_sample <= (i_head.kind == CMD_SAMPLE);
        r_weight     <= wgt[WGT_W-1:0];
        if (r_iss_valid) begin
            r_acc <= sum;
        end
        if (r_iss_valid && r_iss_last) begin
            r_out.fetched_texel <= r_iss_sample ? 8'd0 : r_rd_data;
            r_out.sample_value  <= r_iss_sample ? sum[ACC_W-1:8] : 16'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_iss_valid && r_iss_last) |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrote an untaken output");

    a_taps_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tap != 2'd0) |-> (!i_empty && (i_head.kind == CMD_SAMPLE)))
        else $error("tap counter running without a sample at the queue head");

endmodule
